// ----- rtl/ansi_truecolor_cell_encoder_unit_macros.svh -----
// assertion macros for the truecolor cell encoder
// checks are compiled out when SYNTHESIS is defined
`ifndef ANSI_TRUECOLOR_CELL_ENCODER_UNIT_MACROS_SVH
`define ANSI_TRUECOLOR_CELL_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ATCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ATCE_ASSERT(lbl, prop, msg)
`define ATCE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/atce_pkg.sv -----
// types, constants and helpers of the truecolor cell encoder
// no dependencies
`default_nettype none

package atce_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_FG,
    ST_BG,
    ST_GLYPH
  } atce_state_t;

  localparam logic [0:0] CFG_COLUMNS = 1'b0;
  localparam logic [0:0] CFG_ROWS    = 1'b1;

  localparam int unsigned CFG_W = 10;
  localparam logic [CFG_W-1:0] COLUMNS_RESET = 10'd80;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 10'd25;
  localparam logic [CFG_W-1:0] MAX_ROWS      = 10'd999;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned POS_W = 5;
  typedef logic [POS_W-1:0] atce_pos_t;

  // cursor sequence ESC [ d d d ; 0 0 1 H
  localparam atce_pos_t POS_ROW_HUND = 5'd2;
  localparam atce_pos_t POS_ROW_TENS = 5'd3;
  localparam atce_pos_t POS_ROW_ONES = 5'd4;
  localparam atce_pos_t POS_ROW_LAST = 5'd9;

  // color sequence ESC [ k 8 ; 2 ; ddd ; ddd ; ddd m
  localparam atce_pos_t POS_RED_HUND = 5'd7;
  localparam atce_pos_t POS_GRN_HUND = 5'd11;
  localparam atce_pos_t POS_BLU_HUND = 5'd15;
  localparam atce_pos_t POS_COL_LAST = 5'd18;

  typedef struct packed {
    logic hund;
    logic tens;
    logic ones;
  } atce_digit_ctl_t;

  // threshold k*100 or k*10 for the shared digit step
  function automatic logic [9:0] dig_thr(input logic hund, input logic [3:0] k);
    logic [9:0] kk;
    kk = {6'd0, k};
    return hund ? 10'(kk * 10'd100) : 10'(kk * 10'd10);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/atce_cell_if.sv -----
// cell request channel of the truecolor cell encoder
// no dependencies
`default_nettype none

interface atce_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic [7:0] fg_red;
  logic [7:0] fg_green;
  logic [7:0] fg_blue;
  logic [7:0] bg_red;
  logic [7:0] bg_green;
  logic [7:0] bg_blue;

  modport source (
    output valid, glyph, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
    input  ready
  );
  modport sink (
    input  valid, glyph, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/atce_byte_if.sv -----
// byte stream channel of the truecolor cell encoder
// no dependencies
`default_nettype none

interface atce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_cell;
  logic       end_of_frame;

  modport source (
    output valid, out_byte, last_of_cell, end_of_frame,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_cell, end_of_frame,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ansi_truecolor_cell_encoder_unit.sv -----
// top level of the truecolor cell encoder: sequencer, digit unit, output register
// depends on atce_pkg, atce_cell_if, atce_byte_if and the assertion macros
//
// usage
// in_cell takes one text cell per request: glyph byte plus foreground and
// background rgb. out_stream gives the terminal bytes of that cell, one per
// request: an optional cursor sequence (10 bytes) at the start of a row, an
// optional foreground and background color sequence (19 bytes each) when the
// color changed, then the glyph with last_of_cell set. end_of_frame marks the
// glyph of the last cell of a frame. cfg_we writes columns (index 0) or rows
// (index 1) from cfg_wdata; the user must write them only while no cell is in
// flight, the block itself does not enforce it. a cell of n bytes (1 to 49) is
// taken while the sequencer is idle, which then gives one byte per cycle with an
// open receiver; one shared compare and subtract unit gives the decimal digits.
// in_cell.ready is high only while the sequencer is idle; the next cell is
// taken while the glyph still waits in the output register.
// a stalled receiver holds the output register and freezes the sequencer.
// synchronous reset restores columns 80, rows 25, clears counters and forgets
// the colors, so the first cell emits cursor and both color sequences.
`default_nettype none
`include "ansi_truecolor_cell_encoder_unit_macros.svh"

module ansi_truecolor_cell_encoder_unit
  import atce_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  atce_cell_if.sink             in_cell,
  atce_byte_if.source           out_stream,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  atce_state_t      state_r, state_nxt;
  atce_pos_t        pos_r, pos_nxt;
  logic [CFG_W-1:0] columns_r, rows_r;
  logic [23:0]      last_fg_r, last_bg_r;
  logic             known_r;
  logic [9:0]       col_cnt_r, row_cnt_r;
  logic [9:0]       row_num_r;
  logic [7:0]       glyph_r;
  logic             need_fg_r, need_bg_r, eof_r;
  logic [9:0]       rem_r, rem_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_loc_r, out_eof_r;

  logic [23:0]      in_fg, in_bg;
  logic             accept, can_emit, emit, seg_last;
  logic             need_row_c, need_fg_c, need_bg_c;
  logic [9:0]       cols, nrows, col_inc, row_inc;
  logic             wrap_col, wrap_row;
  logic [10:0]      row_num_raw;
  logic [9:0]       row_num_c;

  atce_digit_ctl_t  dctl;
  logic [9:0]       dig_src;
  logic [3:0]       digit;
  logic [7:0]       digit_ch;
  logic [23:0]      rgb;
  logic [7:0]       byte_c;
  logic             loc_c, eof_c;

  assign in_fg = {in_cell.fg_red, in_cell.fg_green, in_cell.fg_blue};
  assign in_bg = {in_cell.bg_red, in_cell.bg_green, in_cell.bg_blue};

  assign in_cell.ready = (state_r == ST_IDLE);
  assign accept        = in_cell.valid && in_cell.ready;
  assign can_emit      = !out_valid_r || out_stream.ready;
  assign emit          = (state_r != ST_IDLE) && can_emit;

  assign need_row_c = (col_cnt_r == 10'd0);
  assign need_fg_c  = !known_r || (in_fg != last_fg_r);
  assign need_bg_c  = !known_r || (in_bg != last_bg_r);

  // register limits and frame counters
  assign cols     = (columns_r == 10'd0) ? 10'd1 : columns_r;
  assign nrows    = (rows_r == 10'd0) ? 10'd1 : ((rows_r > MAX_ROWS) ? MAX_ROWS : rows_r);
  assign col_inc  = col_cnt_r + 10'd1;
  assign row_inc  = row_cnt_r + 10'd1;
  assign wrap_col = (col_inc >= cols);
  assign wrap_row = wrap_col && (row_inc >= nrows);

  assign row_num_raw = {1'b0, row_cnt_r} + 11'd1;
  assign row_num_c   = (row_num_raw >= 11'd1000) ? 10'(row_num_raw - 11'd1000)
                                                 : row_num_raw[9:0];

  // segment sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    seg_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (need_row_c) state_nxt = ST_ROW;
          else if (need_fg_c) state_nxt = ST_FG;
          else if (need_bg_c) state_nxt = ST_BG;
          else state_nxt = ST_GLYPH;
        end
      end
      ST_ROW: begin
        seg_last = (pos_r == POS_ROW_LAST);
        if (emit && seg_last) begin
          if (need_fg_r) state_nxt = ST_FG;
          else if (need_bg_r) state_nxt = ST_BG;
          else state_nxt = ST_GLYPH;
        end
      end
      ST_FG: begin
        seg_last = (pos_r == POS_COL_LAST);
        if (emit && seg_last) state_nxt = need_bg_r ? ST_BG : ST_GLYPH;
      end
      ST_BG: begin
        seg_last = (pos_r == POS_COL_LAST);
        if (emit && seg_last) state_nxt = ST_GLYPH;
      end
      ST_GLYPH: begin
        seg_last = 1'b1;
        if (emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (emit) pos_nxt = seg_last ? '0 : pos_r + 5'd1;
  end

  // digit control and byte selection
  always_comb begin
    dctl    = '0;
    dig_src = rem_r;
    rgb     = (state_r == ST_FG) ? last_fg_r : last_bg_r;
    byte_c  = CH_SPACE;
    loc_c   = 1'b0;
    eof_c   = 1'b0;

    if (state_r == ST_ROW) begin
      dctl.hund = (pos_r == POS_ROW_HUND);
      dctl.tens = (pos_r == POS_ROW_TENS);
      dctl.ones = (pos_r == POS_ROW_ONES);
      if (dctl.hund) dig_src = row_num_r;
    end else if (state_r == ST_FG || state_r == ST_BG) begin
      dctl.hund = (pos_r == POS_RED_HUND) || (pos_r == POS_GRN_HUND) ||
                  (pos_r == POS_BLU_HUND);
      dctl.tens = (pos_r == POS_RED_HUND + 5'd1) || (pos_r == POS_GRN_HUND + 5'd1) ||
                  (pos_r == POS_BLU_HUND + 5'd1);
      dctl.ones = (pos_r == POS_RED_HUND + 5'd2) || (pos_r == POS_GRN_HUND + 5'd2) ||
                  (pos_r == POS_BLU_HUND + 5'd2);
      if (pos_r == POS_RED_HUND) dig_src = {2'b00, rgb[23:16]};
      else if (pos_r == POS_GRN_HUND) dig_src = {2'b00, rgb[15:8]};
      else if (pos_r == POS_BLU_HUND) dig_src = {2'b00, rgb[7:0]};
    end

    // shared digit unit: one compare and subtract step by 100 or 10
    digit = 4'd0;
    if (dctl.ones) begin
      digit = rem_r[3:0];
    end else begin
      for (int k = 1; k <= 9; k++) begin
        if (dig_src >= dig_thr(dctl.hund, 4'(k))) digit = 4'(k);
      end
    end
    rem_nxt  = dig_src - dig_thr(dctl.hund, digit);
    digit_ch = CH_ZERO | {4'd0, digit};

    unique case (state_r)
      ST_ROW: begin
        case (pos_r) inside
          5'd0:                                   byte_c = CH_ESC;
          5'd1:                                   byte_c = CH_LBRK;
          POS_ROW_HUND, POS_ROW_TENS, POS_ROW_ONES: byte_c = digit_ch;
          5'd5:                                   byte_c = CH_SEMI;
          5'd6, 5'd7:                             byte_c = CH_ZERO;
          5'd8:                                   byte_c = CH_ONE;
          POS_ROW_LAST:                           byte_c = CH_H;
          default:                                byte_c = CH_SPACE;
        endcase
      end
      ST_FG, ST_BG: begin
        case (pos_r) inside
          5'd0:                 byte_c = CH_ESC;
          5'd1:                 byte_c = CH_LBRK;
          5'd2:                 byte_c = (state_r == ST_FG) ? CH_THREE : CH_FOUR;
          5'd3:                 byte_c = CH_EIGHT;
          5'd5:                 byte_c = CH_TWO;
          5'd4, 5'd6, 5'd10, 5'd14: byte_c = CH_SEMI;
          POS_COL_LAST:         byte_c = CH_M;
          default:              byte_c = digit_ch;
        endcase
      end
      ST_GLYPH: begin
        byte_c = (glyph_r == 8'd0) ? CH_SPACE : glyph_r;
        loc_c  = 1'b1;
        eof_c  = eof_r;
      end
      default: byte_c = CH_SPACE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      columns_r   <= COLUMNS_RESET;
      rows_r      <= ROWS_RESET;
      last_fg_r   <= '0;
      last_bg_r   <= '0;
      known_r     <= 1'b0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: columns_r <= cfg_wdata;
          CFG_ROWS:    rows_r    <= cfg_wdata;
        endcase
      end

      if (accept) begin
        if (need_fg_c) last_fg_r <= in_fg;
        if (need_bg_c) last_bg_r <= in_bg;
        known_r   <= !wrap_row;
        col_cnt_r <= wrap_col ? 10'd0 : col_inc;
        if (wrap_col) row_cnt_r <= (row_inc >= nrows) ? 10'd0 : row_inc;
      end

      if (emit) out_valid_r <= 1'b1;
      else if (out_stream.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph_r   <= in_cell.glyph;
      need_fg_r <= need_fg_c;
      need_bg_r <= need_bg_c;
      eof_r     <= wrap_row;
      row_num_r <= row_num_c;
    end
    if (emit && (dctl.hund || dctl.tens)) rem_r <= rem_nxt;
    if (emit) begin
      out_byte_r <= byte_c;
      out_loc_r  <= loc_c;
      out_eof_r  <= eof_c;
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.out_byte     = out_byte_r;
  assign out_stream.last_of_cell = out_loc_r;
  assign out_stream.end_of_frame = out_eof_r;

  `ATCE_ASSERT(a_accept_starts, (accept |=> (state_r != ST_IDLE)), "cell taken but sequencer idle")
  `ATCE_ASSERT(a_glyph_closes, ((emit && state_r == ST_GLYPH) |=> (out_valid_r && out_loc_r)), "glyph byte not marked")
  `ATCE_ASSERT_IMPL(a_eof_on_glyph, out_valid_r && out_eof_r, out_loc_r, "frame end off glyph")
  `ATCE_ASSERT_IMPL(a_ones_digit, emit && dctl.ones, rem_r < 10'd10, "digit remainder too large")

endmodule

`default_nettype wire
